### rtl/core/evad_pkg.sv
// Shared widths, codes and interface types of the energy VAD segmenter.
// No dependencies; imported by every module of the block.
`default_nettype none

package evad_pkg;

   localparam int unsigned SampleWidth   = 16;
   localparam int unsigned MagWidth      = SampleWidth;
   localparam int unsigned ProdWidth     = 2 * MagWidth;
   localparam int unsigned SqWidth       = 2 * (SampleWidth - 1) + 1;
   localparam int unsigned ChunkLenWidth = 13;
   localparam int unsigned EnergyWidth   = 42;
   localparam int unsigned CountWidth    = 16;
   localparam int unsigned MaxChunkLen   = 4096;
   localparam int unsigned QueueDepth    = 4;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = EnergyWidth;

   localparam logic [ChunkLenWidth-1:0] ChunkLenMax = ChunkLenWidth'(MaxChunkLen);

   typedef enum logic [1:0] {
      ACT_DROP,
      ACT_KEEP,
      ACT_DISCARD,
      ACT_COMPLETE
   } action_type;

   typedef enum logic [1:0] {
      SESS_CONTINUE,
      SESS_SEGMENT,
      SESS_EMPTY
   } session_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CHUNK_LENGTH,
      CSR_ENERGY_THRESHOLD,
      CSR_MIN_SPEECH,
      CSR_MAX_SILENCE,
      CSR_SESSION_CHUNKS
   } csr_index_type;

   typedef struct packed {
      logic [CountWidth-1:0] min_speech;
      logic [CountWidth-1:0] max_silence;
      logic [CountWidth-1:0] session_chunks;
   } seg_cfg_type;

   typedef struct packed {
      logic push;
      logic speech;
   } queue_push_type;

   typedef struct packed {
      logic valid;
      logic speech;
   } queue_head_type;

endpackage

`default_nettype wire

### rtl/core/evad_front.sv
// Front end: squares samples, accumulates chunk energy, flags speech chunks.
// Depends on evad_pkg; feeds evad_queue.
`default_nettype none

module evad_front
   import evad_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SampleWidth-1:0] req_sample,
   input  wire logic [ChunkLenWidth-1:0]      cfg_chunk_length,
   input  wire logic [EnergyWidth-1:0]        cfg_threshold,
   input  wire logic                          queue_full,
   output queue_push_type                     push
);

   logic                     adv;
   logic                     accept;
   logic [ChunkLenWidth-1:0] len_eff;
   logic [ChunkLenWidth-1:0] cnt_ff, cnt_in, cnt_inc;
   logic                     chunk_end;
   logic [MagWidth-1:0]      raw, mag;
   logic [ProdWidth-1:0]     prod;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_end_ff, s1_end_in;
   logic [SqWidth-1:0]       sq_ff, sq_in;

   logic [EnergyWidth:0]     sum_wide;
   logic [EnergyWidth-1:0]   sum_sat;
   logic [EnergyWidth-1:0]   acc_ff, acc_in;
   logic                     ev_valid_ff, ev_valid_in;
   logic [EnergyWidth-1:0]   ev_sum_ff, ev_sum_in;

   assign adv       = !(ev_valid_ff && queue_full);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_comb begin
      if (cfg_chunk_length == '0) begin
         len_eff = ChunkLenWidth'(1);
      end else if (cfg_chunk_length > ChunkLenMax) begin
         len_eff = ChunkLenMax;
      end else begin
         len_eff = cfg_chunk_length;
      end
   end

   assign cnt_inc   = cnt_ff + ChunkLenWidth'(1);
   assign chunk_end = cnt_inc >= len_eff;
   assign cnt_in    = accept ? (chunk_end ? '0 : cnt_inc) : cnt_ff;

   assign raw   = req_sample;
   assign mag   = raw[MagWidth-1] ? (~raw + MagWidth'(1)) : raw;
   assign prod  = mag * mag;
   assign sq_in = prod[SqWidth-1:0];

   assign s1_valid_in = adv ? accept : s1_valid_ff;
   assign s1_end_in   = accept ? chunk_end : s1_end_ff;

   assign sum_wide = {1'b0, acc_ff} + (EnergyWidth + 1)'(sq_ff);
   assign sum_sat  = sum_wide[EnergyWidth] ? '1 : sum_wide[EnergyWidth-1:0];

   always_comb begin
      acc_in      = acc_ff;
      ev_valid_in = ev_valid_ff;
      ev_sum_in   = ev_sum_ff;
      if (adv) begin
         ev_valid_in = s1_valid_ff && s1_end_ff;
         if (s1_valid_ff) begin
            acc_in    = s1_end_ff ? '0 : sum_sat;
            ev_sum_in = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         acc_ff      <= acc_in;
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_end_ff <= s1_end_in;
      ev_sum_ff <= ev_sum_in;
      if (accept) begin
         sq_ff <= sq_in;
      end
   end

   assign push.push   = ev_valid_ff && !queue_full;
   assign push.speech = ev_sum_ff > cfg_threshold;

endmodule

`default_nettype wire

### rtl/core/evad_queue.sv
// Short queue of chunk speech flags between front and back ends.
// Depends on evad_pkg.
`default_nettype none

module evad_queue
   import evad_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire queue_push_type push,
   output logic          full,
   input  wire logic     pop,
   output queue_head_type head
);

   logic [QueueDepth-1:0]    mem_ff;
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] cnt_ff, cnt_in;

   function automatic logic [QueuePtrWidth-1:0] ptr_next(input logic [QueuePtrWidth-1:0] p);
      ptr_next = (p == QueuePtrWidth'(QueueDepth - 1)) ? '0 : p + QueuePtrWidth'(1);
   endfunction

   assign full        = cnt_ff == QueueCntWidth'(QueueDepth);
   assign head.valid  = cnt_ff != '0;
   assign head.speech = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = push.push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push.push && !pop) begin
         cnt_in = cnt_ff + QueueCntWidth'(1);
      end else if (pop && !push.push) begin
         cnt_in = cnt_ff - QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem_ff[wr_ptr_ff] <= push.speech;
      end
   end

endmodule

`default_nettype wire

### rtl/core/evad_back.sv
// Back end: segment decisions per chunk, session tracking, result register.
// Depends on evad_pkg; drains evad_queue.
`default_nettype none

module evad_back
   import evad_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire queue_head_type         head,
   output logic                        pop,
   input  wire seg_cfg_type            cfg,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_chunk_action,
   output logic                        rsp_chunk_had_speech,
   output logic [1:0]                  rsp_session_end,
   output logic [CountWidth-1:0]       rsp_kept_chunk_count
);

   logic                  out_free;

   logic [CountWidth-1:0] idx_ff, idx_in;
   logic                  active_ff, active_in;
   logic [CountWidth-1:0] start_ff, start_in;
   logic [CountWidth-1:0] last_ff, last_in;
   logic [CountWidth-1:0] kept_ff, kept_in;

   logic [CountWidth-1:0] kept_inc;
   logic [CountWidth-1:0] silence, span;
   logic [CountWidth-1:0] budget;
   logic [CountWidth-1:0] idx_next;
   logic                  complete;
   action_type            action;
   session_type           send;
   logic [CountWidth-1:0] kept_new;
   logic                  active_new;
   logic [CountWidth-1:0] start_new, last_new;

   logic                  rsp_valid_ff, rsp_valid_in;
   action_type            rsp_action_ff;
   logic                  rsp_speech_ff;
   session_type           rsp_send_ff;
   logic [CountWidth-1:0] rsp_kept_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head.valid && out_free;

   assign kept_inc = (kept_ff == '1) ? kept_ff : kept_ff + CountWidth'(1);
   assign silence  = idx_ff - last_ff;
   assign span     = last_ff - start_ff;
   assign budget   = (cfg.session_chunks == '0) ? CountWidth'(1) : cfg.session_chunks;
   assign idx_next = idx_ff + CountWidth'(1);

   always_comb begin
      action     = ACT_DROP;
      complete   = 1'b0;
      kept_new   = kept_ff;
      active_new = active_ff;
      start_new  = start_ff;
      last_new   = last_ff;
      if (head.speech) begin
         if (!active_ff) begin
            active_new = 1'b1;
            start_new  = idx_ff;
         end
         last_new = idx_ff;
         kept_new = kept_inc;
         action   = ACT_KEEP;
      end else if (active_ff) begin
         if (silence >= cfg.max_silence) begin
            if (span >= cfg.min_speech) begin
               action   = ACT_COMPLETE;
               complete = 1'b1;
            end else begin
               action     = ACT_DISCARD;
               active_new = 1'b0;
               kept_new   = '0;
            end
         end else begin
            kept_new = kept_inc;
            action   = ACT_KEEP;
         end
      end
   end

   always_comb begin
      if (complete) begin
         send = SESS_SEGMENT;
      end else if (idx_next >= budget) begin
         send = (kept_new != '0) ? SESS_SEGMENT : SESS_EMPTY;
      end else begin
         send = SESS_CONTINUE;
      end
   end

   always_comb begin
      idx_in    = idx_ff;
      active_in = active_ff;
      start_in  = start_ff;
      last_in   = last_ff;
      kept_in   = kept_ff;
      if (pop) begin
         if (send != SESS_CONTINUE) begin
            idx_in    = '0;
            active_in = 1'b0;
            start_in  = '0;
            last_in   = '0;
            kept_in   = '0;
         end else begin
            idx_in    = idx_next;
            active_in = active_new;
            start_in  = start_new;
            last_in   = last_new;
            kept_in   = kept_new;
         end
      end
   end

   assign rsp_valid_in = out_free ? head.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         active_ff    <= 1'b0;
         start_ff     <= '0;
         last_ff      <= '0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         active_ff    <= active_in;
         start_ff     <= start_in;
         last_ff      <= last_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_action_ff <= action;
         rsp_speech_ff <= head.speech;
         rsp_send_ff   <= send;
         rsp_kept_ff   <= kept_new;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_chunk_action     = rsp_action_ff;
   assign rsp_chunk_had_speech = rsp_speech_ff;
   assign rsp_session_end      = rsp_send_ff;
   assign rsp_kept_chunk_count = rsp_kept_ff;

   // session state cleared once an end of session is reported
   a_session_clear: assert property (@(posedge clock) disable iff (reset)
      pop && send != SESS_CONTINUE |=> idx_ff == '0 && !active_ff && kept_ff == '0)
      else $error("session state not cleared after session end");

   a_complete_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_action_ff == ACT_COMPLETE |-> rsp_send_ff == SESS_SEGMENT)
      else $error("segment complete without session end");

   a_empty_none_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_send_ff == SESS_EMPTY |-> rsp_kept_ff == '0)
      else $error("empty session reports kept chunks");

   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_action_ff == ACT_DROP |-> !rsp_speech_ff && rsp_kept_ff == '0)
      else $error("dropped chunk with speech or kept chunks");

endmodule

`default_nettype wire

### rtl/core/energy_vad_segmenter.sv
// Top level of the energy VAD segmenter: control registers and the
// front end, queue and back end. Depends on evad_pkg, evad_front,
// evad_queue and evad_back.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall   one signed 16-bit sample
//   rsp_     out        rsp_valid/rsp_stall   one chunk decision
//   csr_     in         csr_write_enable      register index and data
//
// One sample a cycle while req_stall is low. Steps: square into sq_ff,
// accumulate into ev_sum_ff, compare into the queue and decide into rsp_.
// The accumulate loop in the front end sets the one-cycle rate.
// Reset is synchronous; control registers return to their defaults.
// Held rsp_ fills the 4-entry queue; then a waiting chunk raises req_stall.
`default_nettype none

module energy_vad_segmenter
   import evad_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SampleWidth-1:0] req_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_chunk_action,
   output logic                               rsp_chunk_had_speech,
   output logic [1:0]                         rsp_session_end,
   output logic [CountWidth-1:0]              rsp_kept_chunk_count,
   input  wire logic                          csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0]      csr_index,
   input  wire logic [CsrDataWidth-1:0]       csr_write_data
);

   logic [ChunkLenWidth-1:0] chunk_len_ff, chunk_len_in;
   logic [EnergyWidth-1:0]   thr_ff, thr_in;
   seg_cfg_type              seg_cfg_ff, seg_cfg_in;

   queue_push_type           push;
   queue_head_type           head;
   logic                     queue_full;
   logic                     pop;

   always_comb begin
      chunk_len_in = chunk_len_ff;
      thr_in       = thr_ff;
      seg_cfg_in   = seg_cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CHUNK_LENGTH:     chunk_len_in = csr_write_data[ChunkLenWidth-1:0];
            CSR_ENERGY_THRESHOLD: thr_in = csr_write_data[EnergyWidth-1:0];
            CSR_MIN_SPEECH:       seg_cfg_in.min_speech = csr_write_data[CountWidth-1:0];
            CSR_MAX_SILENCE:      seg_cfg_in.max_silence = csr_write_data[CountWidth-1:0];
            CSR_SESSION_CHUNKS:   seg_cfg_in.session_chunks = csr_write_data[CountWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_len_ff              <= ChunkLenWidth'(1600);
         thr_ff                    <= EnergyWidth'(171798692);
         seg_cfg_ff.min_speech     <= CountWidth'(5);
         seg_cfg_ff.max_silence    <= CountWidth'(10);
         seg_cfg_ff.session_chunks <= CountWidth'(100);
      end else begin
         chunk_len_ff <= chunk_len_in;
         thr_ff       <= thr_in;
         seg_cfg_ff   <= seg_cfg_in;
      end
   end

   evad_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .cfg_chunk_length (chunk_len_ff),
      .cfg_threshold    (thr_ff),
      .queue_full       (queue_full),
      .push             (push)
   );

   evad_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   evad_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .pop                  (pop),
      .cfg                  (seg_cfg_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_chunk_action     (rsp_chunk_action),
      .rsp_chunk_had_speech (rsp_chunk_had_speech),
      .rsp_session_end      (rsp_session_end),
      .rsp_kept_chunk_count (rsp_kept_chunk_count)
   );

endmodule

`default_nettype wire
